@@ rtl/swlp_pkg.sv @@
// Shared types and constants for the sliding-window linear predictor.
package swlp_pkg;

    // Default window depth; the top level can override it (legal range 2 to 16).
    localparam int unsigned DEF_WINDOW_DEPTH = 5;

    // Sample and result field width.
    localparam int unsigned SAMPLE_W = 16;

    // Stream widths.
    localparam int unsigned IN_TDATA_W  = 2 * SAMPLE_W;
    localparam int unsigned OUT_TDATA_W = SAMPLE_W;
    localparam int unsigned OUT_TUSER_W = 2;

    // Flag positions in m_axis_tuser.
    localparam int unsigned USER_DEGEN_BIT = 0;
    localparam int unsigned USER_SAT_BIT   = 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_X,
        ST_SXX_ADD,
        ST_SXX_SUB,
        ST_SXY_ADD,
        ST_SXY_SUB,
        ST_DENOM,
        ST_NUMER,
        ST_SLOPE_START,
        ST_SLOPE_WAIT,
        ST_PRED_LO,
        ST_PRED_HI,
        ST_PRED_ADD,
        ST_CLIP,
        ST_DIV_N,
        ST_EMIT
    } t_state;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SUM_X,
        OP_SXX_ADD,
        OP_SXX_SUB,
        OP_SXY_ADD,
        OP_SXY_SUB,
        OP_DENOM,
        OP_NUMER,
        OP_SLOPE_START,
        OP_SLOPE_TAKE,
        OP_PRED_LO,
        OP_PRED_HI,
        OP_PRED_ADD,
        OP_CLIP,
        OP_PRED_TAKE,
        OP_EMIT
    } t_dp_op;

    // Datapath status back to the controller.
    typedef struct packed {
        logic d_pos;    // fit denominator is positive
        logic clip;     // prediction numerator is out of range
        logic div_done; // divider finished this cycle
        logic out_free; // output register can take a result
    } t_dp_sts;

endpackage

@@ rtl/swlp_div.sv @@
// Radix-2 restoring divider for unsigned magnitudes, one quotient bit per cycle.
module swlp_div #(
    parameter int unsigned W  = 40,
    parameter int unsigned CW = $clog2(W + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_dividend, // left-aligned to the iteration count
    input  logic [W-1:0]  i_divisor,
    input  logic [CW-1:0] i_iters,
    output logic          o_done,
    output logic [W-1:0]  o_quot
);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_dsr, n_dsr;
    logic [W:0]    rem_sh;
    logic [W:0]    trial;

    assign rem_sh = {r_rem, r_quo[W-1]};
    assign trial  = rem_sh - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_iters;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_cnt = r_cnt - CW'(1);
            if (!trial[W]) begin
                n_rem = trial[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dsr <= n_dsr;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ rtl/swlp_dp.sv @@
// Datapath: sample window, running sums, shared multiplier, divider and output register.
module swlp_dp import swlp_pkg::*; #(
    parameter int unsigned DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_op                     i_op,
    input  logic [SAMPLE_W-1:0]        i_sample_time,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_m_ready,
    output t_dp_sts                    o_sts,
    output logic                       o_m_valid,
    output logic signed [SAMPLE_W-1:0] o_predicted_value,
    output logic                       o_degenerate,
    output logic                       o_saturated
);

    localparam int unsigned LW   = $clog2(DEPTH + 1);
    localparam int unsigned SXW  = SAMPLE_W + LW;          // Sx, Sy
    localparam int unsigned SXXW = 2 * SAMPLE_W + LW;      // Sxx, Sxy
    localparam int unsigned NW   = 2 * SAMPLE_W + 2 + 2 * LW; // D, N, slope
    localparam int unsigned MW   = SAMPLE_W + 2 + LW;      // multiplier operand
    localparam int unsigned HW   = MW - 1;                 // slope low half
    localparam int unsigned PW   = NW + MW;                // prediction numerator
    localparam int unsigned QW   = SAMPLE_W + 1 + LW;      // |P| width when not clipped
    localparam int unsigned CW   = $clog2(NW + 1);
    localparam int unsigned R_SH = QW + LW;                // reciprocal shift

    localparam logic signed [MW-1:0] N_M = MW'(DEPTH);
    localparam logic signed [NW-1:0] N_N = NW'(DEPTH);
    localparam logic signed [PW-1:0] SAT_HI_P = PW'(32768 * DEPTH);
    localparam logic signed [PW-1:0] SAT_LO_P = PW'(-32769 * int'(DEPTH));

    // ceil(2^R_SH / n): floor(x * RECIP / 2^R_SH) == floor(x / n) for x < 2^QW
    localparam longint unsigned RECIP_L =
        ((64'd1 << R_SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
    localparam logic [R_SH-1:0] RECIP = R_SH'(RECIP_L);

    // window, oldest entry at index 0
    logic [SAMPLE_W-1:0]        r_twin [DEPTH];
    logic signed [SAMPLE_W-1:0] r_vwin [DEPTH];
    logic [SAMPLE_W-1:0]        r_to;
    logic signed [SAMPLE_W-1:0] r_vo;

    logic [SXW-1:0]         r_sx;
    logic signed [SXW-1:0]  r_sy;
    logic [SXXW-1:0]        r_sxx;
    logic signed [SXXW-1:0] r_sxy;

    logic signed [2*MW-1:0] r_prod;
    logic signed [MW-1:0]   r_k;
    logic signed [NW-1:0]   r_d;
    logic signed [NW-1:0]   r_num;
    logic signed [NW-1:0]   r_slope;
    logic                   r_slope_neg;
    logic signed [PW-1:0]   r_p;
    logic                   r_pred_neg;
    logic [QW-1:0]          r_pmag;

    logic signed [SAMPLE_W-1:0] r_pred;
    logic                       r_degen;
    logic                       r_sat;

    logic                       r_m_valid;
    logic signed [SAMPLE_W-1:0] r_m_pred;
    logic                       r_m_degen;
    logic                       r_m_sat;

    logic signed [MW-1:0] tn_m, to_m, vn_m, vo_m, sx_m, sy_m, slo_m, shi_m;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [MW-1:0] tp_m, k_calc;
    logic signed [NW-1:0] sxx_n, sxy_n, prod_n, d_calc, num_calc;
    logic [NW-1:0]        num_mag;
    logic [PW-1:0]        p_mag;
    logic                 sat_hi, sat_lo;
    logic                 div_start, div_done;
    logic [NW-1:0]        div_dvd, div_dsr, div_quot;
    logic [CW-1:0]        div_iters;
    logic [QW+R_SH-1:0]   q_prod;
    logic [SAMPLE_W-1:0]  q_n;

    assign tn_m  = $signed(MW'(r_twin[DEPTH-1]));
    assign to_m  = $signed(MW'(r_to));
    assign vn_m  = MW'(r_vwin[DEPTH-1]);
    assign vo_m  = MW'(r_vo);
    assign sx_m  = $signed(MW'(r_sx));
    assign sy_m  = MW'(r_sy);
    assign slo_m = $signed(MW'(r_slope[HW-1:0]));
    assign shi_m = MW'($signed(r_slope[NW-1:HW]));

    // x offset of the prediction point: n*(t_new + 1) - Sx
    assign tp_m   = $signed(MW'(r_twin[DEPTH-1]) + MW'(1));
    assign k_calc = MW'(N_M * tp_m) - sx_m;

    assign sxx_n    = $signed(NW'(r_sxx));
    assign sxy_n    = NW'(r_sxy);
    assign prod_n   = NW'(r_prod);
    assign d_calc   = N_N * sxx_n - prod_n;
    assign num_calc = N_N * sxy_n - prod_n;
    assign num_mag  = r_num[NW-1] ? NW'(-r_num) : NW'(r_num);
    assign p_mag    = r_p[PW-1] ? PW'(-r_p) : PW'(r_p);
    assign sat_hi   = (r_p >= SAT_HI_P);
    assign sat_lo   = (r_p <= SAT_LO_P);

    // |P| / n by reciprocal multiplication
    assign q_prod = {{R_SH{1'b0}}, r_pmag} * {{QW{1'b0}}, RECIP};
    assign q_n    = q_prod[R_SH +: SAMPLE_W];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            OP_SUM_X:   begin mul_a = tn_m;  mul_b = tn_m; end
            OP_SXX_ADD: begin mul_a = to_m;  mul_b = to_m; end
            OP_SXX_SUB: begin mul_a = tn_m;  mul_b = vn_m; end
            OP_SXY_ADD: begin mul_a = to_m;  mul_b = vo_m; end
            OP_SXY_SUB: begin mul_a = sx_m;  mul_b = sx_m; end
            OP_DENOM:   begin mul_a = sx_m;  mul_b = sy_m; end
            OP_PRED_LO: begin mul_a = slo_m; mul_b = r_k;  end
            OP_PRED_HI: begin mul_a = shi_m; mul_b = r_k;  end
            default:    ;
        endcase
    end

    // divider: slope = |N| / D
    assign div_start = (i_op == OP_SLOPE_START);
    assign div_dvd   = num_mag;
    assign div_dsr   = NW'(r_d);
    assign div_iters = CW'(NW);

    swlp_div #(
        .W  (NW),
        .CW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .i_iters    (div_iters),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // window and running sums are architectural state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_twin[i] <= '0;
                r_vwin[i] <= '0;
            end
        end else if (i_op == OP_LOAD) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_twin[i] <= r_twin[i+1];
                r_vwin[i] <= r_vwin[i+1];
            end
            r_twin[DEPTH-1] <= i_sample_time;
            r_vwin[DEPTH-1] <= i_sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_sxy <= '0;
        end else begin
            case (i_op)
                OP_SUM_X: begin
                    r_sx <= r_sx + SXW'(r_twin[DEPTH-1]) - SXW'(r_to);
                    r_sy <= r_sy + SXW'(r_vwin[DEPTH-1]) - SXW'(r_vo);
                end
                OP_SXX_ADD: r_sxx <= r_sxx + r_prod[SXXW-1:0];
                OP_SXX_SUB: r_sxx <= r_sxx - r_prod[SXXW-1:0];
                OP_SXY_ADD: r_sxy <= r_sxy + $signed(r_prod[SXXW-1:0]);
                OP_SXY_SUB: r_sxy <= r_sxy - $signed(r_prod[SXXW-1:0]);
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_op)
            OP_LOAD: begin
                r_to <= r_twin[0];
                r_vo <= r_vwin[0];
            end
            OP_SXX_ADD: r_k <= k_calc;
            OP_DENOM:   r_d <= d_calc;
            OP_NUMER: begin
                r_num   <= num_calc;
                // degenerate result; replaced later when the fit goes ahead
                r_pred  <= '0;
                r_degen <= 1'b1;
                r_sat   <= 1'b0;
            end
            OP_SLOPE_START: r_slope_neg <= r_num[NW-1];
            OP_SLOPE_TAKE:  r_slope <= r_slope_neg ? -$signed(div_quot) : $signed(div_quot);
            OP_PRED_HI:     r_p <= PW'(r_sy) + PW'(r_prod);
            OP_PRED_ADD:    r_p <= r_p + (PW'(r_prod) <<< HW);
            OP_CLIP: begin
                r_pred_neg <= r_p[PW-1];
                r_pmag     <= p_mag[QW-1:0];
                r_degen    <= 1'b0;
                r_sat      <= sat_hi || sat_lo;
                r_pred     <= sat_hi ? 16'sh7FFF : 16'sh8000;
            end
            OP_PRED_TAKE: begin
                r_pred <= r_pred_neg ? -q_n : q_n;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_op == OP_EMIT) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_EMIT) begin
            r_m_pred  <= r_pred;
            r_m_degen <= r_degen;
            r_m_sat   <= r_sat;
        end
    end

    assign o_sts.d_pos    = !r_d[NW-1] && (r_d != '0);
    assign o_sts.clip     = sat_hi || sat_lo;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_m_valid || i_m_ready;

    assign o_m_valid         = r_m_valid;
    assign o_predicted_value = r_m_pred;
    assign o_degenerate      = r_m_degen;
    assign o_saturated       = r_m_sat;

endmodule

@@ rtl/swlp_ctrl.sv @@
// Controller: sequences one sample through the datapath operations.
module swlp_ctrl import swlp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  t_dp_sts i_sts,
    output t_dp_op  o_op,
    output logic    o_s_ready
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:        if (i_s_valid) n_state = ST_SUM_X;
            ST_SUM_X:       n_state = ST_SXX_ADD;
            ST_SXX_ADD:     n_state = ST_SXX_SUB;
            ST_SXX_SUB:     n_state = ST_SXY_ADD;
            ST_SXY_ADD:     n_state = ST_SXY_SUB;
            ST_SXY_SUB:     n_state = ST_DENOM;
            ST_DENOM:       n_state = ST_NUMER;
            ST_NUMER:       n_state = i_sts.d_pos ? ST_SLOPE_START : ST_EMIT;
            ST_SLOPE_START: n_state = ST_SLOPE_WAIT;
            ST_SLOPE_WAIT:  if (i_sts.div_done) n_state = ST_PRED_LO;
            ST_PRED_LO:     n_state = ST_PRED_HI;
            ST_PRED_HI:     n_state = ST_PRED_ADD;
            ST_PRED_ADD:    n_state = ST_CLIP;
            ST_CLIP:        n_state = i_sts.clip ? ST_EMIT : ST_DIV_N;
            ST_DIV_N:       n_state = ST_EMIT;
            ST_EMIT:        if (i_sts.out_free) n_state = ST_IDLE;
            default:        n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_op      = OP_NONE;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) o_op = OP_LOAD;
            end
            ST_SUM_X:       o_op = OP_SUM_X;
            ST_SXX_ADD:     o_op = OP_SXX_ADD;
            ST_SXX_SUB:     o_op = OP_SXX_SUB;
            ST_SXY_ADD:     o_op = OP_SXY_ADD;
            ST_SXY_SUB:     o_op = OP_SXY_SUB;
            ST_DENOM:       o_op = OP_DENOM;
            ST_NUMER:       o_op = OP_NUMER;
            ST_SLOPE_START: o_op = OP_SLOPE_START;
            ST_SLOPE_WAIT:  if (i_sts.div_done) o_op = OP_SLOPE_TAKE;
            ST_PRED_LO:     o_op = OP_PRED_LO;
            ST_PRED_HI:     o_op = OP_PRED_HI;
            ST_PRED_ADD:    o_op = OP_PRED_ADD;
            ST_CLIP:        o_op = OP_CLIP;
            ST_DIV_N:       o_op = OP_PRED_TAKE;
            ST_EMIT:        if (i_sts.out_free) o_op = OP_EMIT;
            default:        ;
        endcase
    end

endmodule

@@ rtl/sliding_window_linear_predictor_core.sv @@
// Top level of the sliding-window least-squares linear predictor.
// Each input transaction shifts one (time, value) sample into a WINDOW_DEPTH-deep
// window (reset leaves it all zero, and those zero pairs take part in the fit until
// they are shifted out), fits a least-squares line over the whole window with exact
// integer sums and predicts the value at newest time + 1, in Q16.0. Exactly one output
// transaction follows each input transaction: zero with the degenerate flag when all
// window times are equal, or the saturated bound with the saturated flag when the
// prediction leaves the 16-bit range. Samples are handled one at a time. The slope
// comes from the single radix-2 divider, which forms a 34 + 2*L bit quotient with
// L = ceil(log2(WINDOW_DEPTH + 1)); the final divide by the depth is one reciprocal
// multiplication, and the other arithmetic runs in sixteen sequencer steps around
// one shared multiplier. A new sample can be accepted while the previous result
// still waits in the output register.
module sliding_window_linear_predictor_core import swlp_pkg::*; #(
    parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH // 2 to 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [15:0] sample_time, [31:16] sample_value

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [15:0] predicted_value
    output logic [OUT_TUSER_W-1:0] m_axis_tuser   // [0] degenerate, [1] saturated
);

    t_dp_op                     op;
    t_dp_sts                    sts;
    logic signed [SAMPLE_W-1:0] predicted_value;
    logic                       degenerate;
    logic                       saturated;

    // Controller: one state per datapath step, waits on the divider and on the
    // output register.
    swlp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_sts     (sts),
        .o_op      (op),
        .o_s_ready (s_axis_tready)
    );

    // Datapath: window shift line, running sums updated by the entering and the
    // leaving pair, shared multiplier, divider, output register.
    swlp_dp #(
        .DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (op),
        .i_sample_time     (s_axis_tdata[SAMPLE_W-1:0]),
        .i_sample_value    ($signed(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W])),
        .i_m_ready         (m_axis_tready),
        .o_sts             (sts),
        .o_m_valid         (m_axis_tvalid),
        .o_predicted_value (predicted_value),
        .o_degenerate      (degenerate),
        .o_saturated       (saturated)
    );

    assign m_axis_tdata                 = predicted_value;
    assign m_axis_tuser[USER_DEGEN_BIT] = degenerate;
    assign m_axis_tuser[USER_SAT_BIT]   = saturated;

endmodule

@@ rtl/swlp_checker.sv @@
// Port-level checks for the predictor core and their bind to the top level.
module swlp_checker import swlp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped before it was taken");

    // one sample at a time: input closes right after a transaction
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a sample is in flight");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[USER_DEGEN_BIT] && m_axis_tuser[USER_SAT_BIT]))
        else $error("degenerate and saturated both set");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_DEGEN_BIT] |-> m_axis_tdata == '0)
        else $error("degenerate result is not zero");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_SAT_BIT] |->
            m_axis_tdata == 16'h7FFF || m_axis_tdata == 16'h8000)
        else $error("saturated result is not at a bound");

endmodule

bind sliding_window_linear_predictor_core swlp_checker u_swlp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
